### rtl/polyline_length_accumulator_unit_assert.svh
// assertion macros for the polyline length accumulator
// used by the top level only, no other dependencies
`ifndef POLYLINE_LENGTH_ACCUMULATOR_UNIT_ASSERT_SVH
`define POLYLINE_LENGTH_ACCUMULATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PLA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("plen: assertion failed");
// condition must never be seen out of reset
`define PLA_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("plen: forbidden condition seen");
`else
`define PLA_ASSERT(lbl, clk, rstn, prop)
`define PLA_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### rtl/plen_pkg.sv
// shared types and constants for the polyline length accumulator
// no dependencies
`default_nettype none

package plen_pkg;

    localparam int unsigned MAX_POINTS_DEF = 1024;
    localparam int unsigned QUEUE_DEPTH    = 4;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_SUM_MODE  = 3'd0;
    localparam logic [2:0] CFG_WIN_EN    = 3'd1;
    localparam logic [2:0] CFG_WIN_FIRST = 3'd2;
    localparam logic [2:0] CFG_WIN_LAST  = 3'd3;
    localparam logic [2:0] CFG_PERP_EN   = 3'd4;
    localparam logic [2:0] CFG_PERP_X    = 3'd5;
    localparam logic [2:0] CFG_PERP_Y    = 3'd6;
    localparam logic [2:0] CFG_PERP_Z    = 3'd7;

    // job kinds handed from front to back
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_STEP = 2'd1;
    localparam logic [1:0] KIND_GEOM = 2'd2;

    typedef struct packed {
        logic               sum_mode;
        logic               win_en;
        logic        [9:0]  win_first;
        logic        [9:0]  win_last;
        logic               perp_en;
        logic signed [15:0] perp_x;
        logic signed [15:0] perp_y;
        logic signed [15:0] perp_z;
    } t_cfg;

    typedef struct packed {
        logic        [1:0]  kind;
        logic               last;
        logic        [10:0] total;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic signed [24:0] dz;
        logic        [23:0] step;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic pop;
        logic emit;
    } t_back_stat;

endpackage

`default_nettype wire

### rtl/plen_front.sv
// front end: accepts points, keeps point index and previous point, classifies
// each point into a job for the back end; depends on plen_pkg
`default_nettype none

module plen_front #(
    parameter int unsigned MAX_POINTS = plen_pkg::MAX_POINTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire plen_pkg::t_cfg     i_cfg,
    input  wire logic               i_valid,
    input  wire logic signed [23:0] i_pos_x,
    input  wire logic signed [23:0] i_pos_y,
    input  wire logic signed [23:0] i_pos_z,
    input  wire logic signed [23:0] i_step_len,
    input  wire logic               i_point_valid,
    input  wire logic               i_last_point,
    input  wire plen_pkg::t_q_stat  i_q_stat,
    output logic                    o_ready,
    output logic                    o_push,
    output plen_pkg::t_job          o_job
);
    import plen_pkg::*;

    localparam int IW = $clog2(MAX_POINTS + 1);
    localparam int CW = ((IW > 10) ? IW : 10) + 1;

    logic        [IW-1:0] r_idx;
    logic        [IW-1:0] n_idx;
    logic signed [23:0]   r_prev_x;
    logic signed [23:0]   r_prev_y;
    logic signed [23:0]   r_prev_z;

    logic [CW-1:0] idx_c;
    logic [CW-1:0] wf_c;
    logic [CW-1:0] wl_c;
    logic [CW-1:0] tot_c;
    logic          step_win;
    logic          step_cnt;
    logic          geom_win;

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && o_ready;

    // index saturates at the point limit
    assign n_idx = (r_idx < IW'(MAX_POINTS)) ? r_idx + 1'b1 : r_idx;

    assign idx_c = CW'(r_idx);
    assign wf_c  = CW'(i_cfg.win_first);
    assign wl_c  = CW'(i_cfg.win_last);
    assign tot_c = CW'(n_idx);

    always_comb begin
        step_win = !i_cfg.win_en ||
                   (!i_last_point && idx_c >= wf_c && (idx_c + 1'b1) <= wl_c);
        step_cnt = step_win && i_point_valid && !i_step_len[23] && (i_step_len != '0);
        geom_win = (r_idx != '0) &&
                   (!i_cfg.win_en || ((idx_c - 1'b1) >= wf_c && idx_c <= wl_c));

        o_job.last  = i_last_point;
        o_job.total = tot_c[10:0];
        o_job.dx    = {i_pos_x[23], i_pos_x} - {r_prev_x[23], r_prev_x};
        o_job.dy    = {i_pos_y[23], i_pos_y} - {r_prev_y[23], r_prev_y};
        o_job.dz    = {i_pos_z[23], i_pos_z} - {r_prev_z[23], r_prev_z};
        o_job.step  = i_step_len;
        if (i_cfg.sum_mode) begin
            o_job.kind = step_cnt ? KIND_STEP : KIND_NONE;
        end else begin
            o_job.kind = geom_win ? KIND_GEOM : KIND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_prev_z <= '0;
        end else if (o_push) begin
            if (i_last_point) begin
                r_idx    <= '0;
                r_prev_x <= '0;
                r_prev_y <= '0;
                r_prev_z <= '0;
            end else begin
                r_idx    <= n_idx;
                r_prev_x <= i_pos_x;
                r_prev_y <= i_pos_y;
                r_prev_z <= i_pos_z;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/plen_fifo.sv
// short job queue between front and back end
// depends on plen_pkg
`default_nettype none

module plen_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire plen_pkg::t_job    i_job,
    input  wire logic              i_pop,
    output plen_pkg::t_job         o_job,
    output plen_pkg::t_q_stat      o_stat
);
    import plen_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_job            r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_cnt;

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/plen_back.sv
// back end: squares, dot product, bit-serial square root, saturating sum and
// the result register; depends on plen_pkg
`default_nettype none

module plen_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire plen_pkg::t_cfg       i_cfg,
    input  wire plen_pkg::t_job       i_job,
    input  wire plen_pkg::t_q_stat    i_q_stat,
    input  wire logic                 i_out_ready,
    output plen_pkg::t_back_stat      o_stat,
    output logic                      o_out_valid,
    output logic [39:0]               o_track_length,
    output logic [10:0]               o_point_total
);
    import plen_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MAC  = 3'd1;
    localparam logic [2:0] B_PRND = 3'd2;
    localparam logic [2:0] B_PSQ  = 3'd3;
    localparam logic [2:0] B_SQRT = 3'd4;
    localparam logic [2:0] B_RND  = 3'd5;
    localparam logic [2:0] B_ACC  = 3'd6;
    localparam logic [2:0] B_FIN  = 3'd7;

    localparam int          ROOT_W    = 25;
    localparam logic [4:0]  SQRT_LAST = 5'(ROOT_W - 1);

    logic [2:0]         r_state;
    t_job               r_job;
    logic [2:0]         r_k;
    logic [49:0]        r_mag2;
    logic signed [42:0] r_dot;
    logic [27:0]        r_p;
    logic [49:0]        r_rad;
    logic [26:0]        r_rem;
    logic [24:0]        r_root;
    logic [4:0]         r_cnt;
    logic [25:0]        r_add;
    logic [39:0]        r_acc;
    logic               r_out_valid;
    logic [39:0]        r_out_len;
    logic [10:0]        r_out_total;

    logic signed [28:0] mul_a;
    logic signed [28:0] mul_b;
    logic signed [57:0] prod;
    logic [49:0]        n_mag2;
    logic signed [42:0] n_dot;
    logic [42:0]        dot_abs;
    logic [43:0]        dot_rnd;
    logic [55:0]        p2;
    logic [49:0]        n_rad_perp;
    logic [28:0]        sq_sh;
    logic [28:0]        sq_trial;
    logic               sq_ge;
    logic [28:0]        sq_diff;
    logic [40:0]        acc_sum;
    logic [39:0]        n_acc;
    logic               pop;
    logic               emit;

    // one shared signed multiplier, operands picked by state and step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == B_PSQ) begin
            mul_a = {1'b0, r_p};
            mul_b = {1'b0, r_p};
        end else begin
            case (r_k)
                3'd0: begin mul_a = 29'(r_job.dx); mul_b = 29'(r_job.dx); end
                3'd1: begin mul_a = 29'(r_job.dy); mul_b = 29'(r_job.dy); end
                3'd2: begin mul_a = 29'(r_job.dz); mul_b = 29'(r_job.dz); end
                3'd3: begin mul_a = 29'(r_job.dx); mul_b = 29'(i_cfg.perp_x); end
                3'd4: begin mul_a = 29'(r_job.dy); mul_b = 29'(i_cfg.perp_y); end
                3'd5: begin mul_a = 29'(r_job.dz); mul_b = 29'(i_cfg.perp_z); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign prod   = mul_a * mul_b;
    assign n_mag2 = r_mag2 + prod[49:0];
    assign n_dot  = r_dot + prod[42:0];

    // dot rounded half away from zero to 1/256 units
    assign dot_abs = r_dot[42] ? 43'(-r_dot) : 43'(r_dot);
    assign dot_rnd = {1'b0, dot_abs} + 44'(1 << 14);

    // radicand clamped at zero
    assign p2         = prod[55:0];
    assign n_rad_perp = (p2 >= {6'd0, r_mag2}) ? '0 : 50'({6'd0, r_mag2} - p2);

    // restoring square root, one root bit per cycle
    assign sq_sh    = {r_rem, r_rad[49:48]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);
    assign sq_diff  = sq_sh - sq_trial;

    assign acc_sum = {1'b0, r_acc} + 41'(r_add);
    assign n_acc   = acc_sum[40] ? '1 : acc_sum[39:0];

    assign pop  = (r_state == B_IDLE) && !i_q_stat.empty;
    assign emit = (r_state == B_FIN) && (!r_out_valid || i_out_ready);

    assign o_stat.pop      = pop;
    assign o_stat.emit     = emit;
    assign o_out_valid     = r_out_valid;
    assign o_track_length  = r_out_len;
    assign o_point_total   = r_out_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_cnt       <= '0;
        end else begin
            // a new result fills an empty output register or replaces the one just taken
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (pop) begin
                        r_job  <= i_job;
                        r_k    <= '0;
                        r_mag2 <= '0;
                        r_dot  <= '0;
                        if (i_job.kind == KIND_GEOM) begin
                            r_state <= B_MAC;
                        end else begin
                            r_add   <= (i_job.kind == KIND_STEP) ? 26'(i_job.step) : '0;
                            r_state <= B_ACC;
                        end
                    end
                end
                B_MAC: begin
                    r_k <= r_k + 1'b1;
                    if (r_k <= 3'd2) begin
                        r_mag2 <= n_mag2;
                    end else begin
                        r_dot <= n_dot;
                    end
                    if (r_k == 3'd2 && !i_cfg.perp_en) begin
                        r_rad   <= n_mag2;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= B_SQRT;
                    end else if (r_k == 3'd5) begin
                        r_state <= B_PRND;
                    end
                end
                B_PRND: begin
                    r_p     <= dot_rnd[42:15];
                    r_state <= B_PSQ;
                end
                B_PSQ: begin
                    r_rad   <= n_rad_perp;
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    r_rem  <= sq_ge ? sq_diff[26:0] : sq_sh[26:0];
                    r_root <= {r_root[23:0], sq_ge};
                    r_rad  <= {r_rad[47:0], 2'b00};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == SQRT_LAST) begin
                        r_state <= B_RND;
                    end
                end
                B_RND: begin
                    r_add   <= 26'(r_root) + 26'(r_rem > {2'b00, r_root});
                    r_state <= B_ACC;
                end
                B_ACC: begin
                    r_acc   <= n_acc;
                    r_state <= r_job.last ? B_FIN : B_IDLE;
                end
                B_FIN: begin
                    if (emit) begin
                        r_acc   <= '0;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_len   <= r_acc;
            r_out_total <= r_job.total;
        end
    end

endmodule

`default_nettype wire

### rtl/polyline_length_accumulator_unit.sv
// Polyline length accumulator. Points of a track stream in; when the point
// marked last has been summed, one item carries the track length (1/256 units,
// saturating at 2^40-1) and the point count. Geometric mode sums distances
// between consecutive points, optionally with the component along the
// configured Q1.15 vector removed; step mode sums positive step lengths of
// valid points. A front end accepts one point per cycle while its job queue
// (four entries) has room; the back end works one job at a time. For a
// geometric pair the back end takes the job, runs three multiply-accumulate
// steps on one shared multiplier (six, plus rounding and squaring of the
// projection, when it is removed), a bit-serial square root giving a 25-bit
// root, then rounding and the add; the square root sets the sustained rate.
// Step points and points that add nothing go from taking the job straight
// to the add; a final point then passes a finish state that loads the
// output register. A finished result waits in the output register while
// the next points are already being taken and worked on. The user must
// write configuration registers through the plain write port while the
// block is idle (not enforced by the block); no clearing pass follows reset.
//
// depends on plen_pkg, plen_front, plen_fifo, plen_back and the assertion header
`default_nettype none
`include "polyline_length_accumulator_unit_assert.svh"

module polyline_length_accumulator_unit #(
    parameter int unsigned MAX_POINTS = plen_pkg::MAX_POINTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write port
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_addr,
    input  wire logic [15:0]  i_cfg_wdata,
    // point stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,  // pos_x, pos_y, pos_z, step_len
    input  wire logic [0:0]   s_axis_tuser,  // point_valid
    input  wire logic         s_axis_tlast,  // last_point
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [55:0]       m_axis_tdata   // track_length, point_total, zero pad
);
    import plen_pkg::*;

    t_cfg        r_cfg;
    t_job        front_job;
    t_job        q_job;
    t_q_stat     q_stat;
    t_back_stat  back_stat;
    logic        push;
    logic [39:0] track_length;
    logic [10:0] point_total;

    // configuration registers, read by both ends at every job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sum_mode  <= 1'b0;
            r_cfg.win_en    <= 1'b0;
            r_cfg.win_first <= '0;
            r_cfg.win_last  <= 10'd1023;
            r_cfg.perp_en   <= 1'b0;
            r_cfg.perp_x    <= '0;
            r_cfg.perp_y    <= '0;
            r_cfg.perp_z    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SUM_MODE:  r_cfg.sum_mode  <= i_cfg_wdata[0];
                CFG_WIN_EN:    r_cfg.win_en    <= i_cfg_wdata[0];
                CFG_WIN_FIRST: r_cfg.win_first <= i_cfg_wdata[9:0];
                CFG_WIN_LAST:  r_cfg.win_last  <= i_cfg_wdata[9:0];
                CFG_PERP_EN:   r_cfg.perp_en   <= i_cfg_wdata[0];
                CFG_PERP_X:    r_cfg.perp_x    <= i_cfg_wdata;
                CFG_PERP_Y:    r_cfg.perp_y    <= i_cfg_wdata;
                CFG_PERP_Z:    r_cfg.perp_z    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // front end: index window, pair differences, job kind
    plen_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .i_pos_x       (s_axis_tdata[23:0]),
        .i_pos_y       (s_axis_tdata[47:24]),
        .i_pos_z       (s_axis_tdata[71:48]),
        .i_step_len    (s_axis_tdata[95:72]),
        .i_point_valid (s_axis_tuser[0]),
        .i_last_point  (s_axis_tlast),
        .i_q_stat      (q_stat),
        .o_ready       (s_axis_tready),
        .o_push        (push),
        .o_job         (front_job)
    );

    // jobs in flight between the two ends
    plen_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (back_stat.pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    // back end: distance, square root, accumulation, result register
    plen_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_job          (q_job),
        .i_q_stat       (q_stat),
        .i_out_ready    (m_axis_tready),
        .o_stat         (back_stat),
        .o_out_valid    (m_axis_tvalid),
        .o_track_length (track_length),
        .o_point_total  (point_total)
    );

    assign m_axis_tdata = {5'd0, point_total, track_length};

    // queue bookkeeping stays consistent
    `PLA_NEVER(a_q_full_and_empty, i_clk, i_rst_n, q_stat.full && q_stat.empty)
    // back end only takes a job that is there
    `PLA_ASSERT(a_pop_nonempty, i_clk, i_rst_n, back_stat.pop |-> !q_stat.empty)
    // a waiting result is never overwritten
    `PLA_ASSERT(a_no_overwrite, i_clk, i_rst_n,
                back_stat.emit |-> (!m_axis_tvalid || m_axis_tready))

endmodule

`default_nettype wire
